// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// Depends on nothing; synthesis builds define SYNTH to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BGCA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("bgca assertion failed");
`define BGCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bgca assertion failed");
`else
`define BGCA_ASSERT(lbl, clk, rstn, prop)
`define BGCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== design/bgca_pkg.sv =====
// Types and constants of the cave grid automaton.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bgca_pkg;
    localparam int MAX_DIM   = 64;
    localparam int ROW_W     = $clog2(MAX_DIM);
    localparam int CFG_DIM_W = 7;
    localparam int PASS_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RUN   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_PASSES = 2'd2,
        REG_UNUSED = 2'd3
    } cfg_idx_t;

    typedef logic [MAX_DIM-1:0] row_t;
    typedef row_t [4:0] window_t;

    typedef struct packed {
        logic [1:0] op;
        logic [5:0] col;
        logic [5:0] row;
        logic       cell_in;
    } cmd_t;

    typedef struct packed {
        logic cell_out;
        logic run_done;
        logic out_of_range;
    } res_t;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
        row_t             data;
        row_t             mask;
    } ram_wr_t;
endpackage
`default_nettype wire

// ===== design/bgca_ram.sv =====
// Row-wide grid memory: one bit-masked write port, one registered read port.
// Depends on bgca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bgca_ram (
    input  wire                       clk,
    input  bgca_pkg::ram_wr_t         wr,
    input  wire                       rd_en,
    input  wire [bgca_pkg::ROW_W-1:0] rd_addr,
    output bgca_pkg::row_t            rd_data
);
    bgca_pkg::row_t mem [bgca_pkg::MAX_DIM];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            for (int i = 0; i < bgca_pkg::MAX_DIM; i++)
            begin
                if (wr.mask[i])
                begin
                    mem[wr.addr][i] <= wr.data[i];
                end
            end
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== design/bgca_rule.sv =====
// Next-row logic: applies the cave rule to the centre row of a 5-row window.
// Depends on bgca_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bgca_rule (
    input  bgca_pkg::window_t win,
    output bgca_pkg::row_t    next_row
);
    localparam int PAD_W = bgca_pkg::MAX_DIM + 4;

    logic [PAD_W-1:0] pad [5];
    logic [2:0]       h5  [5][bgca_pkg::MAX_DIM];
    logic [1:0]       h3  [5][bgca_pkg::MAX_DIM];

    always_comb
    begin
        for (int r = 0; r < 5; r++)
        begin
            pad[r] = {2'b00, win[r], 2'b00};
        end
        for (int r = 0; r < 5; r++)
        begin
            for (int c = 0; c < bgca_pkg::MAX_DIM; c++)
            begin
                h3[r][c] = 2'({1'b0, pad[r][c+1]}) + 2'({1'b0, pad[r][c+2]})
                         + 2'({1'b0, pad[r][c+3]});
                h5[r][c] = 3'(h3[r][c]) + 3'({2'b00, pad[r][c]})
                         + 3'({2'b00, pad[r][c+4]});
            end
        end
    end

    always_comb
    begin
        logic [3:0] n8;
        logic [4:0] n24;
        logic       ctr;
        n8  = '0;
        n24 = '0;
        ctr = 1'b0;
        for (int c = 0; c < bgca_pkg::MAX_DIM; c++)
        begin
            ctr = win[2][c];
            n8  = 4'(h3[1][c]) + 4'(h3[2][c]) + 4'(h3[3][c]) - 4'({3'b000, ctr});
            n24 = 5'(h5[0][c]) + 5'(h5[1][c]) + 5'(h5[2][c]) + 5'(h5[3][c])
                + 5'(h5[4][c]) - 5'({4'b0000, ctr});
            if (ctr)
            begin
                next_row[c] = (n8 >= 4'd3);
            end
            else
            begin
                next_row[c] = (n8 >= 4'd5) || (n24 <= 5'd2);
            end
        end
    end
endmodule
`default_nettype wire

// ===== design/binary_grid_cave_automaton.sv =====
// Top level of the cave grid automaton: command decode, pass sequencer, result.
// Depends on bgca_pkg, bgca_ram, bgca_rule and assert_macros.svh.
//
// channel  | signals                       | handshake
// command  | start, busy, cmd              | word taken when start && !busy
// result   | done, result                  | one-cycle strobe, no stall
// config   | cfg_valid, cfg_ready, idx/dat | taken when valid && ready
//
// Cell writes and reads go one per cycle while not busy; a result passes the c1 and res registers.
// During a run, each pass reads, updates and writes back one grid row per cycle
// through the single memory.
// After reset the grid is swept to zero, one row a cycle, while busy is high.
// Config is always ready; results cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module binary_grid_cave_automaton (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    output logic                          busy,
    input  bgca_pkg::cmd_t                cmd,
    output logic                          done,
    output bgca_pkg::res_t                result,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire [bgca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [bgca_pkg::CFG_DAT_W-1:0] cfg_data
);
    localparam int DW = bgca_pkg::CFG_DIM_W;
    localparam int RW = bgca_pkg::ROW_W;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [DW-1:0]              cnt_reg, cnt_next;
    logic [bgca_pkg::PASS_W-1:0] pass_reg, pass_next;
    logic [DW-1:0]              width_reg, height_reg;
    logic [bgca_pkg::PASS_W-1:0] passes_cfg_reg;
    bgca_pkg::window_t          win_reg;
    logic                       rv1_reg, rv2_reg;
    logic [DW-1:0]              rtag1_reg, rtag2_reg;
    logic                       c1_v_reg, c1_oor_reg;
    bgca_pkg::op_t              c1_op_reg;
    logic [5:0]                 c1_col_reg;
    logic                       res_v_reg;
    bgca_pkg::res_t             res_reg, res_next;

    logic [DW-1:0]   wu, hu;
    bgca_pkg::row_t  colmask, rd_data, rowin, rule_row;
    bgca_pkg::ram_wr_t wr;
    logic            rd_en;
    logic [RW-1:0]   rd_addr;
    logic            accept, oor, run_go, run_fin, drain_ok;
    bgca_pkg::op_t   op_in;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign op_in     = bgca_pkg::op_t'(cmd.op);
    assign wu = (width_reg > DW'(bgca_pkg::MAX_DIM)) ? DW'(bgca_pkg::MAX_DIM) : width_reg;
    assign hu = (height_reg > DW'(bgca_pkg::MAX_DIM)) ? DW'(bgca_pkg::MAX_DIM) : height_reg;
    assign oor = (DW'(cmd.col) >= wu) || (DW'(cmd.row) >= hu);
    assign run_go = (passes_cfg_reg != '0) && (wu != '0) && (hu != '0);
    assign drain_ok = !rv1_reg && !rv2_reg;
    assign run_fin = (state_reg == ST_DRAIN) && drain_ok
                   && (pass_reg == bgca_pkg::PASS_W'(1));

    always_comb
    begin
        for (int i = 0; i < bgca_pkg::MAX_DIM; i++)
        begin
            colmask[i] = (DW'(i) < wu);
        end
    end

    assign rowin = (rtag1_reg < hu) ? (rd_data & colmask) : '0;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cnt_next = cnt_reg + DW'(1);
                if (cnt_reg == DW'(bgca_pkg::MAX_DIM - 1))
                begin
                    state_next = ST_IDLE;
                    cnt_next   = '0;
                end
            end
            ST_IDLE:
            begin
                if (accept && op_in == bgca_pkg::OP_RUN && run_go)
                begin
                    state_next = ST_READ;
                    cnt_next   = '0;
                    pass_next  = passes_cfg_reg;
                end
            end
            ST_READ:
            begin
                cnt_next = cnt_reg + DW'(1);
                if (cnt_reg == hu + DW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_ok)
                begin
                    cnt_next = '0;
                    if (pass_reg == bgca_pkg::PASS_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                        pass_next  = pass_reg - bgca_pkg::PASS_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        wr      = '0;
        rd_en   = 1'b0;
        rd_addr = cmd.row;
        if (state_reg == ST_CLEAR)
        begin
            wr.en   = 1'b1;
            wr.addr = cnt_reg[RW-1:0];
            wr.mask = '1;
        end
        else if (rv2_reg && rtag2_reg >= DW'(2))
        begin
            wr.en   = 1'b1;
            wr.addr = RW'(rtag2_reg - DW'(2));
            wr.data = rule_row;
            wr.mask = colmask;
        end
        else if (accept && op_in == bgca_pkg::OP_WRITE && !oor)
        begin
            wr.en   = 1'b1;
            wr.addr = cmd.row;
            wr.data = {bgca_pkg::MAX_DIM{cmd.cell_in}};
            for (int i = 0; i < bgca_pkg::MAX_DIM; i++)
            begin
                wr.mask[i] = (cmd.col == RW'(i));
            end
        end
        if (state_reg == ST_READ)
        begin
            rd_en   = 1'b1;
            rd_addr = cnt_reg[RW-1:0];
        end
        else if (accept && op_in == bgca_pkg::OP_READ && !oor)
        begin
            rd_en = 1'b1;
        end
    end

    always_comb
    begin
        res_next = '0;
        if (run_fin)
        begin
            res_next.run_done = 1'b1;
        end
        else
        begin
            case (c1_op_reg)
                bgca_pkg::OP_WRITE: res_next.out_of_range = c1_oor_reg;
                bgca_pkg::OP_READ:
                begin
                    res_next.out_of_range = c1_oor_reg;
                    res_next.cell_out     = !c1_oor_reg && rd_data[c1_col_reg];
                end
                bgca_pkg::OP_RUN:   res_next.run_done = 1'b1;
                default:            ;
            endcase
        end
    end

    bgca_ram u_ram (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bgca_rule u_rule (
        .win      (win_reg),
        .next_row (rule_row)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            pass_reg       <= '0;
            width_reg      <= DW'(64);
            height_reg     <= DW'(64);
            passes_cfg_reg <= bgca_pkg::PASS_W'(4);
            rv1_reg        <= 1'b0;
            rv2_reg        <= 1'b0;
            c1_v_reg       <= 1'b0;
            res_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pass_reg  <= pass_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (bgca_pkg::cfg_idx_t'(cfg_index))
                    bgca_pkg::REG_WIDTH:  width_reg      <= cfg_data[DW-1:0];
                    bgca_pkg::REG_HEIGHT: height_reg     <= cfg_data[DW-1:0];
                    bgca_pkg::REG_PASSES: passes_cfg_reg <= cfg_data;
                    default:              ;
                endcase
            end
            rv1_reg   <= (state_reg == ST_READ);
            rv2_reg   <= rv1_reg;
            c1_v_reg  <= accept && !(op_in == bgca_pkg::OP_RUN && run_go);
            res_v_reg <= c1_v_reg || run_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        rtag1_reg  <= cnt_reg;
        rtag2_reg  <= rtag1_reg;
        c1_op_reg  <= op_in;
        c1_oor_reg <= oor;
        c1_col_reg <= cmd.col;
        if (rv1_reg)
        begin
            win_reg <= {rowin, win_reg[4:1]};
        end
        else if (state_next == ST_READ && state_reg != ST_READ)
        begin
            win_reg <= '0;
        end
        res_reg <= res_next;
    end

    assign done   = res_v_reg;
    assign result = res_reg;

    `BGCA_ASSERT(a_pass_write_in_grid, clk, rst_n,
        !(wr.en && (state_reg == ST_READ || state_reg == ST_DRAIN)) || (DW'(wr.addr) < hu))
    `BGCA_ASSERT(a_idle_pipe_empty, clk, rst_n, busy || (!rv1_reg && !rv2_reg))
    `BGCA_ASSERT_NEXT(a_cell_result, clk, rst_n,
        accept && op_in != bgca_pkg::OP_RUN, ##1 done)
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for binary_grid_cave_automaton: a predictor grid inside a scoreboard
// class, directed and random command words, config settings and random idling.
// Depends on bgca_pkg and the RTL of the block.
`timescale 1ns / 1ps
`default_nettype none

class cave_scoreboard;
    bit [63:0]      grid [64];
    bit [6:0]       width_reg;
    bit [6:0]       height_reg;
    bit [7:0]       passes_reg;
    bgca_pkg::res_t want_q [$];
    int             errors;
    int             checked;
    int             runs;

    function void reset_state();
        foreach (grid[i]) grid[i] = '0;
        width_reg  = 7'd64;
        height_reg = 7'd64;
        passes_reg = 8'd4;
        want_q.delete();
    endfunction

    function int used_w();
        return (width_reg > 64) ? 64 : width_reg;
    endfunction

    function int used_h();
        return (height_reg > 64) ? 64 : height_reg;
    endfunction

    function void set_reg(bgca_pkg::cfg_idx_t idx, bit [7:0] data);
        case (idx)
            bgca_pkg::REG_WIDTH:  width_reg  = data[6:0];
            bgca_pkg::REG_HEIGHT: height_reg = data[6:0];
            bgca_pkg::REG_PASSES: passes_reg = data;
            default: ;
        endcase
    endfunction

    function int live_near(int c, int r, int rad, int w, int h);
        int n;
        n = 0;
        for (int dr = -rad; dr <= rad; dr++)
            for (int dc = -rad; dc <= rad; dc++)
                if (!(dr == 0 && dc == 0) && r + dr >= 0 && r + dr < h &&
                    c + dc >= 0 && c + dc < w)
                    n += grid[r + dr][c + dc];
        return n;
    endfunction

    function void evolve(int w, int h);
        bit [63:0] nxt [64];
        int        n8;
        nxt = grid;
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
            begin
                n8 = live_near(c, r, 1, w, h);
                if (grid[r][c])
                    nxt[r][c] = (n8 >= 3);
                else
                    nxt[r][c] = (n8 >= 5) || (live_near(c, r, 2, w, h) <= 2);
            end
        grid = nxt;
    endfunction

    function void note_cmd(bgca_pkg::cmd_t cmd);
        bgca_pkg::res_t res;
        int             w;
        int             h;
        res = '0;
        w   = used_w();
        h   = used_h();
        case (bgca_pkg::op_t'(cmd.op))
            bgca_pkg::OP_WRITE, bgca_pkg::OP_READ:
            begin
                if (cmd.col >= w || cmd.row >= h)
                    res.out_of_range = 1'b1;
                else if (cmd.op == bgca_pkg::OP_WRITE)
                    grid[cmd.row][cmd.col] = cmd.cell_in;
                else
                    res.cell_out = grid[cmd.row][cmd.col];
            end
            bgca_pkg::OP_RUN:
            begin
                if (w > 0 && h > 0)
                    for (int p = 0; p < passes_reg; p++)
                        evolve(w, h);
                res.run_done = 1'b1;
                runs++;
            end
            default: ;
        endcase
        want_q = {want_q, res};
    endfunction

    function void check_result(bgca_pkg::res_t got);
        bgca_pkg::res_t want;
        checked++;
        if (want_q.size() == 0)
        begin
            $display("%0t: unexpected result %b", $time, got);
            errors++;
            return;
        end
        want = want_q.pop_front();
        if (got.cell_out !== want.cell_out)
        begin
            $display("%0t: cell_out expected %b actual %b", $time, want.cell_out, got.cell_out);
            errors++;
        end
        if (got.run_done !== want.run_done)
        begin
            $display("%0t: run_done expected %b actual %b", $time, want.run_done, got.run_done);
            errors++;
        end
        if (got.out_of_range !== want.out_of_range)
        begin
            $display("%0t: out_of_range expected %b actual %b", $time,
                     want.out_of_range, got.out_of_range);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int LIMIT = 3000000;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    bgca_pkg::cmd_t cmd;
    logic           done;
    bgca_pkg::res_t result;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [1:0]     cfg_index;
    logic [7:0]     cfg_data;

    cave_scoreboard sb;
    int             cycles;
    int             words;
    int             settings;

    binary_grid_cave_automaton dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && done)
            sb.check_result(result);
        if (cycles > LIMIT)
        begin
            $display("binary_grid_cave_automaton regression: fail");
            $finish;
        end
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send(bgca_pkg::op_t op, int col, int row, bit val);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       = 1'b1;
        cmd.op      = op;
        cmd.col     = col[5:0];
        cmd.row     = row[5:0];
        cmd.cell_in = val;
        do
            @(posedge clk);
        while (busy);
        sb.note_cmd(cmd);
        words++;
        @(negedge clk);
    endtask

    task automatic idle_wait();
        start = 1'b0;
        while (sb.want_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(bgca_pkg::cfg_idx_t idx, bit [7:0] data);
        repeat (gap_len()) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic setup(bit [7:0] w, bit [7:0] h, bit [7:0] p);
        idle_wait();
        write_reg(bgca_pkg::REG_WIDTH, w);
        write_reg(bgca_pkg::REG_HEIGHT, h);
        write_reg(bgca_pkg::REG_PASSES, p);
        settings++;
    endtask

    task automatic random_phase(int count);
        int w;
        int h;
        int roll;
        int col;
        int row;
        int dens;
        w    = sb.used_w();
        h    = sb.used_h();
        dens = $urandom_range(90, 10);
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if ($urandom_range(99) < 85 && w > 0 && h > 0)
            begin
                col = $urandom_range(w - 1);
                row = $urandom_range(h - 1);
            end
            else
            begin
                col = $urandom_range(63);
                row = $urandom_range(63);
            end
            if (roll < 50)
                send(bgca_pkg::OP_WRITE, col, row, $urandom_range(99) < dens);
            else if (roll < 89)
                send(bgca_pkg::OP_READ, col, row, $urandom_range(1));
            else if (roll < 95)
                send(bgca_pkg::OP_RUN, col, row, $urandom_range(1));
            else
                send(bgca_pkg::OP_NONE, col, row, $urandom_range(1));
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        cycles    = 0;
        words     = 0;
        settings  = 1;
        rst_n     = 1'b0;
        start     = 1'b0;
        cmd       = '0;
        cfg_valid = 1'b0;
        cfg_index = bgca_pkg::REG_WIDTH;
        cfg_data  = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        send(bgca_pkg::OP_WRITE, 0, 0, 1'b1);
        send(bgca_pkg::OP_WRITE, 63, 63, 1'b1);
        send(bgca_pkg::OP_READ, 0, 0, 1'b0);
        send(bgca_pkg::OP_READ, 63, 63, 1'b0);
        send(bgca_pkg::OP_READ, 42, 21, 1'b1);
        send(bgca_pkg::OP_NONE, 63, 63, 1'b1);
        send(bgca_pkg::OP_RUN, 0, 0, 1'b0);
        send(bgca_pkg::OP_READ, 32, 32, 1'b0);
        setup(8'd5, 8'd3, 8'd255);
        send(bgca_pkg::OP_WRITE, 5, 0, 1'b1);
        send(bgca_pkg::OP_READ, 0, 3, 1'b0);
        send(bgca_pkg::OP_WRITE, 2, 1, 1'b1);
        send(bgca_pkg::OP_RUN, 0, 0, 1'b0);
        send(bgca_pkg::OP_READ, 4, 2, 1'b0);
        setup(8'd0, 8'd64, 8'd1);
        send(bgca_pkg::OP_WRITE, 0, 0, 1'b1);
        send(bgca_pkg::OP_READ, 0, 0, 1'b0);
        send(bgca_pkg::OP_RUN, 0, 0, 1'b0);
        setup(8'd127, 8'd100, 8'd0);
        write_reg(bgca_pkg::REG_UNUSED, 8'hff);
        send(bgca_pkg::OP_RUN, 0, 0, 1'b0);
        send(bgca_pkg::OP_READ, 63, 63, 1'b0);
        setup(8'd64, 8'd0, 8'd2);
        send(bgca_pkg::OP_READ, 1, 0, 1'b0);
        send(bgca_pkg::OP_RUN, 0, 0, 1'b0);
        setup(8'd1, 8'd1, 8'd3);
        send(bgca_pkg::OP_WRITE, 0, 0, 1'b0);
        send(bgca_pkg::OP_RUN, 0, 0, 1'b0);
        send(bgca_pkg::OP_READ, 0, 0, 1'b0);

        for (int ph = 0; ph < 12; ph++)
        begin
            int w;
            int h;
            int p;
            int roll;
            roll = $urandom_range(99);
            w = (roll < 15) ? 64 : (roll < 25) ? $urandom_range(8, 1) : $urandom_range(64, 1);
            h = ($urandom_range(99) < 15) ? 64 : $urandom_range(64, 1);
            if ($urandom_range(99) < 5)
                w = $urandom_range(1) ? 0 : $urandom_range(255, 65);
            p = $urandom_range(5);
            if (ph == 3)
            begin
                h = $urandom_range(4, 1);
                p = 255;
            end
            setup(w[7:0], h[7:0], p[7:0]);
            random_phase(110);
        end

        idle_wait();
        $display("%0d command words over %0d register settings, %0d runs, %0d results checked",
                 words, settings, sb.runs, sb.checked);
        if (sb.errors == 0)
            $display("binary_grid_cave_automaton regression: pass");
        else
            $display("binary_grid_cave_automaton regression: fail");
        $finish;
    end
endmodule

`default_nettype wire
